FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the color ramp block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define HSBCR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("color ramp check failed");

// Condition that must never be seen at a clock edge outside reset.
`define HSBCR_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("color ramp forbidden condition seen");

`endif

FILE: rtl/hsbcr_pkg.sv
// Shared types, constants and codes of the HSB color ramp generator.
package hsbcr_pkg;

  // Largest ramp length that the entry count may select.
  localparam int unsigned MAX_ENTRIES = 256;

  // Field and register widths.
  localparam int unsigned HUE_W     = 20;
  localparam int unsigned UNIT_W    = 17;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned INDEX_W   = 8;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned FRAC_W    = 32;
  localparam int unsigned UNIT_LSB  = 16;
  localparam int unsigned F16_W     = 16;
  localparam int unsigned SPAN_W    = HUE_W + 1;
  localparam int unsigned DIV_W     = SPAN_W + UNIT_LSB;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  // Datapath widths of the channel arithmetic.
  localparam int unsigned K_W     = UNIT_W + 8;
  localparam int unsigned KS_W    = K_W + UNIT_W;
  localparam int unsigned KSF_W   = KS_W + F16_W;
  localparam int unsigned MUL_A_W = KS_W;
  localparam int unsigned MUL_B_W = UNIT_W;
  localparam int unsigned NUM_W   = KSF_W + 2;

  // Configuration port.
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // Register reset values.
  localparam logic [UNIT_W-1:0]  UNIT_ONE      = UNIT_W'(65536);
  localparam logic [HUE_W-1:0]   HUE_ONE_TURN  = HUE_W'(65536);
  localparam logic [COUNT_W-1:0] COUNT_DEFAULT = COUNT_W'(256);

  // Register map, by word index.
  typedef enum logic [2:0] {
    REG_START_HUE    = 3'd0,
    REG_START_SAT    = 3'd1,
    REG_START_BRIGHT = 3'd2,
    REG_END_HUE      = 3'd3,
    REG_END_SAT      = 3'd4,
    REG_END_BRIGHT   = 3'd5,
    REG_ENTRY_COUNT  = 3'd6
  } reg_idx_e;

  // Which span the divider is working on.
  typedef enum logic [1:0] {
    SEL_HUE,
    SEL_SAT,
    SEL_BRIGHT
  } span_sel_e;

  // Hue sectors of the six-sector color wheel.
  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } sector_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LAUNCH,
    ST_DIV_WAIT,
    ST_PREP,
    ST_MUL_KS,
    ST_MUL_KSF,
    ST_EMIT
  } seq_state_e;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [HUE_W-1:0]   start_hue;
    logic [UNIT_W-1:0]  start_sat;
    logic [UNIT_W-1:0]  start_bright;
    logic [HUE_W-1:0]   end_hue;
    logic [UNIT_W-1:0]  end_sat;
    logic [UNIT_W-1:0]  end_bright;
    logic [COUNT_W-1:0] entry_count;
  } cfg_t;

  // Divider request and response.
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/hsbcr_cfg.sv
// APB-style configuration register file of the color ramp generator.
module hsbcr_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hsbcr_pkg::PADDR_W-1:0]   paddr,
  input  logic [hsbcr_pkg::PDATA_W-1:0]   pwdata,
  output logic [hsbcr_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready,
  output hsbcr_pkg::cfg_t                 cfg_o
);

  hsbcr_pkg::cfg_t      cfg_q;
  hsbcr_pkg::reg_idx_e  reg_idx;
  logic                 wr_en;

  // Word index from the byte address.
  assign reg_idx = hsbcr_pkg::reg_idx_e'(paddr[hsbcr_pkg::PADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  // Register writes; an address past the last register is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_hue    <= '0;
      cfg_q.start_sat    <= hsbcr_pkg::UNIT_ONE;
      cfg_q.start_bright <= hsbcr_pkg::UNIT_ONE;
      cfg_q.end_hue      <= hsbcr_pkg::HUE_ONE_TURN;
      cfg_q.end_sat      <= hsbcr_pkg::UNIT_ONE;
      cfg_q.end_bright   <= hsbcr_pkg::UNIT_ONE;
      cfg_q.entry_count  <= hsbcr_pkg::COUNT_DEFAULT;
    end else if (wr_en) begin
      unique case (reg_idx)
        hsbcr_pkg::REG_START_HUE:    cfg_q.start_hue <= pwdata[hsbcr_pkg::HUE_W-1:0];
        hsbcr_pkg::REG_START_SAT:    cfg_q.start_sat <= pwdata[hsbcr_pkg::UNIT_W-1:0];
        hsbcr_pkg::REG_START_BRIGHT: cfg_q.start_bright <= pwdata[hsbcr_pkg::UNIT_W-1:0];
        hsbcr_pkg::REG_END_HUE:      cfg_q.end_hue <= pwdata[hsbcr_pkg::HUE_W-1:0];
        hsbcr_pkg::REG_END_SAT:      cfg_q.end_sat <= pwdata[hsbcr_pkg::UNIT_W-1:0];
        hsbcr_pkg::REG_END_BRIGHT:   cfg_q.end_bright <= pwdata[hsbcr_pkg::UNIT_W-1:0];
        hsbcr_pkg::REG_ENTRY_COUNT:  cfg_q.entry_count <= pwdata[hsbcr_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      hsbcr_pkg::REG_START_HUE:    prdata = hsbcr_pkg::PDATA_W'(cfg_q.start_hue);
      hsbcr_pkg::REG_START_SAT:    prdata = hsbcr_pkg::PDATA_W'(cfg_q.start_sat);
      hsbcr_pkg::REG_START_BRIGHT: prdata = hsbcr_pkg::PDATA_W'(cfg_q.start_bright);
      hsbcr_pkg::REG_END_HUE:      prdata = hsbcr_pkg::PDATA_W'(cfg_q.end_hue);
      hsbcr_pkg::REG_END_SAT:      prdata = hsbcr_pkg::PDATA_W'(cfg_q.end_sat);
      hsbcr_pkg::REG_END_BRIGHT:   prdata = hsbcr_pkg::PDATA_W'(cfg_q.end_bright);
      hsbcr_pkg::REG_ENTRY_COUNT:  prdata = hsbcr_pkg::PDATA_W'(cfg_q.entry_count);
      default:                     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/hsbcr_div.sv
// Bit-serial restoring divider for the per-entry increments.
module hsbcr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hsbcr_pkg::div_req_t req_i,
  output hsbcr_pkg::div_rsp_t rsp_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [hsbcr_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [hsbcr_pkg::DIV_W-1:0]       quo_q;
  logic [hsbcr_pkg::COUNT_W-1:0]     rem_q;
  logic [hsbcr_pkg::COUNT_W-1:0]     divisor_q;
  logic [hsbcr_pkg::COUNT_W:0]       trial;
  logic [hsbcr_pkg::COUNT_W:0]       trial_sub;
  logic                              fits;

  // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
  assign trial     = {rem_q, quo_q[hsbcr_pkg::DIV_W-1]};
  assign trial_sub = trial - {1'b0, divisor_q};
  assign fits      = (trial >= {1'b0, divisor_q});

  // Control: iteration counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == hsbcr_pkg::DIV_CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= hsbcr_pkg::DIV_CNT_W'(hsbcr_pkg::DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - hsbcr_pkg::DIV_CNT_W'(1);
        if (cnt_q == hsbcr_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q     <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[hsbcr_pkg::DIV_W-2:0], fits};
      rem_q <= fits ? trial_sub[hsbcr_pkg::COUNT_W-1:0] : trial[hsbcr_pkg::COUNT_W-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: rtl/hsbcr_hsv.sv
// Six-sector HSV to RGB mapping from the registered products.
module hsbcr_hsv (
  input  logic [hsbcr_pkg::K_W-1:0]    k_i,
  input  logic [hsbcr_pkg::KS_W-1:0]   ks_i,
  input  logic [hsbcr_pkg::KSF_W-1:0]  ksf_i,
  input  hsbcr_pkg::sector_e           sector_i,
  output logic [hsbcr_pkg::CHAN_W-1:0] red_o,
  output logic [hsbcr_pkg::CHAN_W-1:0] green_o,
  output logic [hsbcr_pkg::CHAN_W-1:0] blue_o
);

  // Floor of a signed value scaled down by 2^sh, clamped to 0..255.
  function automatic logic [hsbcr_pkg::CHAN_W-1:0] sat8(
    input logic [hsbcr_pkg::NUM_W-1:0] num,
    input int unsigned                 sh
  );
    logic [hsbcr_pkg::NUM_W-1:0]   shifted;
    logic [hsbcr_pkg::CHAN_W-1:0]  res;
    shifted = num >> sh;
    if (num[hsbcr_pkg::NUM_W-1]) begin
      res = '0;
    end else if (|shifted[hsbcr_pkg::NUM_W-1:hsbcr_pkg::CHAN_W]) begin
      res = '1;
    end else begin
      res = shifted[hsbcr_pkg::CHAN_W-1:0];
    end
    return res;
  endfunction

  logic [hsbcr_pkg::NUM_W-1:0]  kx;
  logic [hsbcr_pkg::NUM_W-1:0]  ksx;
  logic [hsbcr_pkg::NUM_W-1:0]  ksfx;
  logic [hsbcr_pkg::NUM_W-1:0]  p_num;
  logic [hsbcr_pkg::NUM_W-1:0]  q_num;
  logic [hsbcr_pkg::NUM_W-1:0]  t_num;
  logic [hsbcr_pkg::CHAN_W-1:0] v_val;
  logic [hsbcr_pkg::CHAN_W-1:0] p_val;
  logic [hsbcr_pkg::CHAN_W-1:0] q_val;
  logic [hsbcr_pkg::CHAN_W-1:0] t_val;

  // With k = 255 B and ks = k S:
  //   p = k (1 - S), q = k (1 - S f), t = k (1 - S (1 - f)).
  assign kx    = hsbcr_pkg::NUM_W'(k_i);
  assign ksx   = hsbcr_pkg::NUM_W'(ks_i);
  assign ksfx  = hsbcr_pkg::NUM_W'(ksf_i);
  assign p_num = (kx << 16) - ksx;
  assign q_num = (kx << 32) - ksfx;
  assign t_num = (kx << 32) - (ksx << 16) + ksfx;

  assign v_val = sat8(kx, 16);
  assign p_val = sat8(p_num, 32);
  assign q_val = sat8(q_num, 48);
  assign t_val = sat8(t_num, 48);

  // Sector selects the channel order.
  always_comb begin
    unique case (sector_i)
      hsbcr_pkg::SECT_RED_YEL: begin
        red_o = v_val; green_o = t_val; blue_o = p_val;
      end
      hsbcr_pkg::SECT_YEL_GRN: begin
        red_o = q_val; green_o = v_val; blue_o = p_val;
      end
      hsbcr_pkg::SECT_GRN_CYN: begin
        red_o = p_val; green_o = v_val; blue_o = t_val;
      end
      hsbcr_pkg::SECT_CYN_BLU: begin
        red_o = p_val; green_o = q_val; blue_o = v_val;
      end
      hsbcr_pkg::SECT_BLU_MAG: begin
        red_o = t_val; green_o = p_val; blue_o = v_val;
      end
      default: begin
        red_o = v_val; green_o = p_val; blue_o = q_val;
      end
    endcase
  end

endmodule

FILE: rtl/hsb_color_ramp_generator.sv
// Top level of the HSB color ramp generator: sequencer, accumulators, shared multiplier.
//
//   channel   signals                               direction
//   request   in_valid_i / in_ready_o, restart_i     in
//   result    out_valid_o / out_ready_i, RGB, index  out
//   config    psel penable pwrite paddr pwdata ...   APB, in/out
//
// A plain request passes through the states that prepare operands, make two passes through the
// shared multiplier, then load the output register.
// A reload (restart, first request, or request after the last entry) adds
// three 37-bit serial divisions, one each for the hue, saturation and brightness spans.
// in_ready_o is high only while the sequencer is idle; a finished result waits
// in the output register and holds the sequencer until it is taken.
// Reset clears the sequencer, the output valid flag and the ramp-started flag.
module hsb_color_ramp_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hsbcr_pkg::PADDR_W-1:0]  paddr,
  input  logic [hsbcr_pkg::PDATA_W-1:0]  pwdata,
  output logic [hsbcr_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [hsbcr_pkg::CHAN_W-1:0]   red_o,
  output logic [hsbcr_pkg::CHAN_W-1:0]   green_o,
  output logic [hsbcr_pkg::CHAN_W-1:0]   blue_o,
  output logic [hsbcr_pkg::INDEX_W-1:0]  entry_index_o,
  output logic                           last_entry_o
);

  // Accumulator value to a 16-fraction-bit unit in 0..131071.
  function automatic logic [hsbcr_pkg::UNIT_W-1:0] unit16(
    input logic [hsbcr_pkg::ACC_W-1:0] acc
  );
    logic [hsbcr_pkg::UNIT_W-1:0] res;
    if (acc[hsbcr_pkg::ACC_W-1]) begin
      res = '0;
    end else if (|acc[hsbcr_pkg::ACC_W-2:hsbcr_pkg::UNIT_LSB+hsbcr_pkg::UNIT_W]) begin
      res = '1;
    end else begin
      res = acc[hsbcr_pkg::UNIT_LSB+hsbcr_pkg::UNIT_W-1:hsbcr_pkg::UNIT_LSB];
    end
    return res;
  endfunction

  hsbcr_pkg::cfg_t        cfg;
  hsbcr_pkg::div_req_t    div_req;
  hsbcr_pkg::div_rsp_t    div_rsp;
  hsbcr_pkg::seq_state_e  state_q, state_d;
  hsbcr_pkg::span_sel_e   sel_q;
  hsbcr_pkg::sector_e     sector_q;

  logic                              started_q;
  logic                              out_valid_q;
  logic [hsbcr_pkg::ACC_W-1:0]       hue_acc_q, sat_acc_q, bright_acc_q;
  logic [hsbcr_pkg::ACC_W-1:0]       hue_step_q, sat_step_q, bright_step_q;
  logic [hsbcr_pkg::COUNT_W-1:0]     counter_q;
  logic [hsbcr_pkg::K_W-1:0]         k_q;
  logic [hsbcr_pkg::UNIT_W-1:0]      s16_q;
  logic [hsbcr_pkg::F16_W-1:0]       f16_q;
  logic [hsbcr_pkg::KS_W-1:0]        ks_q;
  logic [hsbcr_pkg::KSF_W-1:0]       ksf_q;
  logic [hsbcr_pkg::CHAN_W-1:0]      red_q, green_q, blue_q;
  logic [hsbcr_pkg::INDEX_W-1:0]     index_q;
  logic                              last_q;

  logic                              accept;
  logic                              reload;
  logic                              emit_go;
  logic                              is_last;
  logic [hsbcr_pkg::COUNT_W-1:0]     eff_count;
  logic [hsbcr_pkg::SPAN_W-1:0]      span;
  logic [hsbcr_pkg::SPAN_W-1:0]      span_mag;
  logic                              span_neg;
  logic [hsbcr_pkg::ACC_W-1:0]       step_val;
  logic [hsbcr_pkg::FRAC_W+2:0]      h6;
  logic [hsbcr_pkg::UNIT_W-1:0]      b16;
  logic [hsbcr_pkg::K_W-1:0]         k_d;
  logic [hsbcr_pkg::MUL_A_W-1:0]     mul_a;
  logic [hsbcr_pkg::MUL_B_W-1:0]     mul_b;
  logic [hsbcr_pkg::MUL_A_W+hsbcr_pkg::MUL_B_W-1:0] mul_p;
  logic [hsbcr_pkg::CHAN_W-1:0]      red_c, green_c, blue_c;

  hsbcr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hsbcr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  hsbcr_hsv u_hsv (
    .k_i      (k_q),
    .ks_i     (ks_q),
    .ksf_i    (ksf_q),
    .sector_i (sector_q),
    .red_o    (red_c),
    .green_o  (green_c),
    .blue_o   (blue_c)
  );

  // Effective entry count: zero means one, large values saturate.
  always_comb begin
    if (cfg.entry_count == '0) begin
      eff_count = hsbcr_pkg::COUNT_W'(1);
    end else if (int'(cfg.entry_count) > hsbcr_pkg::MAX_ENTRIES) begin
      eff_count = hsbcr_pkg::COUNT_W'(hsbcr_pkg::MAX_ENTRIES);
    end else begin
      eff_count = cfg.entry_count;
    end
  end

  assign is_last = ({1'b0, counter_q} + 10'd1) >= {1'b0, eff_count};

  // Span end minus start for the channel under division, as sign and magnitude.
  always_comb begin
    case (sel_q)
      hsbcr_pkg::SEL_HUE:
        span = {cfg.end_hue[hsbcr_pkg::HUE_W-1], cfg.end_hue}
             - {cfg.start_hue[hsbcr_pkg::HUE_W-1], cfg.start_hue};
      hsbcr_pkg::SEL_SAT:
        span = hsbcr_pkg::SPAN_W'(cfg.end_sat) - hsbcr_pkg::SPAN_W'(cfg.start_sat);
      default:
        span = hsbcr_pkg::SPAN_W'(cfg.end_bright) - hsbcr_pkg::SPAN_W'(cfg.start_bright);
    endcase
  end

  assign span_neg = span[hsbcr_pkg::SPAN_W-1];
  assign span_mag = span_neg ? (~span + hsbcr_pkg::SPAN_W'(1)) : span;
  assign step_val = span_neg ? (~hsbcr_pkg::ACC_W'(div_rsp.quotient) + hsbcr_pkg::ACC_W'(1))
                             : hsbcr_pkg::ACC_W'(div_rsp.quotient);

  // Hue times six: sector in the integer bits, f in the top fraction bits.
  assign h6  = {2'b00, hue_acc_q[hsbcr_pkg::FRAC_W-1:0], 1'b0}
             + {1'b0, hue_acc_q[hsbcr_pkg::FRAC_W-1:0], 2'b00};
  assign b16 = unit16(bright_acc_q);
  assign k_d = {b16, 8'd0} - hsbcr_pkg::K_W'(b16);

  // Shared multiplier: k * S first, then (k * S) * f.
  assign mul_p = mul_a * mul_b;

  // Sequencer: next state, divider launch and multiplier operands.
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = {span_mag, hsbcr_pkg::UNIT_LSB'(0)};
    div_req.divisor  = eff_count;
    mul_a            = hsbcr_pkg::MUL_A_W'(k_q);
    mul_b            = s16_q;
    accept           = 1'b0;
    emit_go          = 1'b0;
    unique case (state_q)
      hsbcr_pkg::ST_IDLE: begin
        accept = in_valid_i;
        if (in_valid_i) begin
          state_d = reload ? hsbcr_pkg::ST_DIV_LAUNCH : hsbcr_pkg::ST_PREP;
        end
      end
      hsbcr_pkg::ST_DIV_LAUNCH: begin
        div_req.start = 1'b1;
        state_d       = hsbcr_pkg::ST_DIV_WAIT;
      end
      hsbcr_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = (sel_q == hsbcr_pkg::SEL_BRIGHT) ? hsbcr_pkg::ST_PREP
                                                     : hsbcr_pkg::ST_DIV_LAUNCH;
        end
      end
      hsbcr_pkg::ST_PREP: begin
        state_d = hsbcr_pkg::ST_MUL_KS;
      end
      hsbcr_pkg::ST_MUL_KS: begin
        state_d = hsbcr_pkg::ST_MUL_KSF;
      end
      hsbcr_pkg::ST_MUL_KSF: begin
        mul_a   = ks_q;
        mul_b   = hsbcr_pkg::MUL_B_W'(f16_q);
        state_d = hsbcr_pkg::ST_EMIT;
      end
      hsbcr_pkg::ST_EMIT: begin
        emit_go = !out_valid_q || out_ready_i;
        if (emit_go) begin
          state_d = hsbcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hsbcr_pkg::ST_IDLE;
      end
    endcase
  end

  assign reload     = restart_i || !started_q;
  assign in_ready_o = (state_q == hsbcr_pkg::ST_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsbcr_pkg::ST_IDLE;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && reload) begin
        started_q <= 1'b1;
      end else if (emit_go && is_last) begin
        started_q <= 1'b0;
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Ramp state: reload, increments, stepping after each entry but the last.
  always_ff @(posedge clk_i) begin
    if (accept && reload) begin
      hue_acc_q    <= {{4{cfg.start_hue[hsbcr_pkg::HUE_W-1]}}, cfg.start_hue,
                       hsbcr_pkg::UNIT_LSB'(0)};
      sat_acc_q    <= {7'd0, cfg.start_sat, hsbcr_pkg::UNIT_LSB'(0)};
      bright_acc_q <= {7'd0, cfg.start_bright, hsbcr_pkg::UNIT_LSB'(0)};
      counter_q    <= '0;
      sel_q        <= hsbcr_pkg::SEL_HUE;
    end else if (emit_go && !is_last) begin
      hue_acc_q    <= hue_acc_q + hue_step_q;
      sat_acc_q    <= sat_acc_q + sat_step_q;
      bright_acc_q <= bright_acc_q + bright_step_q;
      counter_q    <= counter_q + hsbcr_pkg::COUNT_W'(1);
    end
    if (state_q == hsbcr_pkg::ST_DIV_WAIT && div_rsp.done) begin
      case (sel_q)
        hsbcr_pkg::SEL_HUE: begin
          hue_step_q <= step_val;
          sel_q      <= hsbcr_pkg::SEL_SAT;
        end
        hsbcr_pkg::SEL_SAT: begin
          sat_step_q <= step_val;
          sel_q      <= hsbcr_pkg::SEL_BRIGHT;
        end
        default: begin
          bright_step_q <= step_val;
        end
      endcase
    end
  end

  // Conversion operands and products.
  always_ff @(posedge clk_i) begin
    if (state_q == hsbcr_pkg::ST_PREP) begin
      k_q      <= k_d;
      s16_q    <= unit16(sat_acc_q);
      f16_q    <= h6[hsbcr_pkg::FRAC_W-1:hsbcr_pkg::FRAC_W-hsbcr_pkg::F16_W];
      sector_q <= hsbcr_pkg::sector_e'(h6[hsbcr_pkg::FRAC_W+2:hsbcr_pkg::FRAC_W]);
    end
    if (state_q == hsbcr_pkg::ST_MUL_KS) begin
      ks_q <= mul_p[hsbcr_pkg::KS_W-1:0];
    end
    if (state_q == hsbcr_pkg::ST_MUL_KSF) begin
      ksf_q <= mul_p[hsbcr_pkg::KSF_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      red_q   <= red_c;
      green_q <= green_c;
      blue_q  <= blue_c;
      index_q <= counter_q[hsbcr_pkg::INDEX_W-1:0];
      last_q  <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign entry_index_o = index_q;
  assign last_entry_o  = last_q;

endmodule

FILE: rtl/hsbcr_checker.sv
// Port-level checks of the color ramp generator, bound to the top level.
`include "assert_macros.svh"

module hsbcr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          pready,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [hsbcr_pkg::CHAN_W-1:0]  red_o,
  input logic [hsbcr_pkg::CHAN_W-1:0]  green_o,
  input logic [hsbcr_pkg::CHAN_W-1:0]  blue_o,
  input logic [hsbcr_pkg::INDEX_W-1:0] entry_index_o,
  input logic                          last_entry_o
);

  logic [3*hsbcr_pkg::CHAN_W+hsbcr_pkg::INDEX_W:0] out_payload;

  // Every result field in one vector, so a stall can be checked as a whole.
  assign out_payload = {red_o, green_o, blue_o, entry_index_o, last_entry_o};

  // A pending result stays offered until taken.
  `HSBCR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)

  // A stalled result keeps its payload.
  `HSBCR_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_payload))

  // The sequencer is busy right after it takes an item.
  `HSBCR_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o)

  // The configuration port never inserts wait states.
  `HSBCR_NEVER(a_pready_low, !pready)

endmodule

bind hsb_color_ramp_generator hsbcr_checker u_hsbcr_checker (.*);
